/* rtl/core/gwm_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and helpers of the glob wildcard matcher
package gwm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int CHAR_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int LEN_W       = 6;
    localparam int PAT_REGS    = 4;
    localparam int BYTES_PER_REG = CFG_DATA_W / CHAR_W;

    localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_QMARK  = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PAT0 = 3'd0,
        REG_PAT1 = 3'd1,
        REG_PAT2 = 3'd2,
        REG_PAT3 = 3'd3,
        REG_LEN  = 3'd4
    } t_cfg_reg;

    // per-position pattern info handed to each cell
    typedef struct packed {
        logic              in_use;
        logic              star;
        logic              qmark;
        logic [CHAR_W-1:0] folded;
    } t_cell_cfg;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        fold_case = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_OFFSET : c;
    endfunction

endpackage

/* rtl/core/gwm_cell.sv */
`timescale 1ns / 1ps
// one pattern position of the matcher chain
module gwm_cell (
    input  gwm_pkg::t_cell_cfg         i_cfg,
    input  logic [gwm_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_seed,
    input  logic                       i_carry,
    output logic                       o_closed,
    output logic                       o_carry,
    output logic                       o_step_self,
    output logic                       o_step_next
);
    import gwm_pkg::*;

    // active after star closure from the left neighbor
    assign o_closed    = i_seed | i_carry;
    assign o_carry     = o_closed & i_cfg.in_use & i_cfg.star;
    // star stays put, other bytes advance on a match
    assign o_step_self = o_closed & i_cfg.in_use & i_cfg.star;
    assign o_step_next = o_closed & i_cfg.in_use & ~i_cfg.star
                       & (i_cfg.qmark | (i_cfg.folded == i_char));

endmodule

/* rtl/core/gwm_cfg.sv */
`timescale 1ns / 1ps
// pattern registers and per-position cell setup
module gwm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [gwm_pkg::CFG_ADDR_W-1:0] i_addr,
    input  logic [gwm_pkg::CFG_DATA_W-1:0] i_data,
    output gwm_pkg::t_cell_cfg             o_cell [gwm_pkg::PATTERN_MAX]
);
    import gwm_pkg::*;

    logic [CFG_DATA_W-1:0] r_pat [PAT_REGS];
    logic [CFG_DATA_W-1:0] n_pat [PAT_REGS];
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      n_len;
    t_cell_cfg             r_cell [PATTERN_MAX];
    t_cell_cfg             n_cell [PATTERN_MAX];

    logic [LEN_W-1:0]       len_eff;
    logic [PATTERN_MAX:0]   len_mask;
    logic [PATTERN_MAX-1:0] zero_vec;
    logic [PATTERN_MAX-1:0] first_zero;
    logic [PATTERN_MAX-1:0] before_zero;
    logic [PATTERN_MAX-1:0] use_vec;
    logic [CHAR_W-1:0]      pbyte [PATTERN_MAX];

    always_comb begin
        for (int r = 0; r < PAT_REGS; r++) begin
            n_pat[r] = r_pat[r];
        end
        n_len = r_len;
        if (i_wr) begin
            case (i_addr)
                REG_PAT0: n_pat[0] = i_data;
                REG_PAT1: n_pat[1] = i_data;
                REG_PAT2: n_pat[2] = i_data;
                REG_PAT3: n_pat[3] = i_data;
                REG_LEN:  n_len    = i_data[LEN_W-1:0];
                default:  n_len    = r_len;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pbyte[i]    = n_pat[i / BYTES_PER_REG][(i % BYTES_PER_REG) * CHAR_W +: CHAR_W];
            zero_vec[i] = (pbyte[i] == CHAR_NUL);
        end
        len_eff     = (n_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : n_len;
        len_mask    = ((PATTERN_MAX+1)'(1) << len_eff) - (PATTERN_MAX+1)'(1);
        // positions below the first zero byte; all ones when none is zero
        first_zero  = zero_vec & (~zero_vec + PATTERN_MAX'(1));
        before_zero = first_zero - PATTERN_MAX'(1);
        use_vec     = before_zero & len_mask[PATTERN_MAX-1:0];
        for (int i = 0; i < PATTERN_MAX; i++) begin
            n_cell[i].in_use = use_vec[i];
            n_cell[i].star   = (pbyte[i] == CHAR_STAR);
            n_cell[i].qmark  = (pbyte[i] == CHAR_QMARK);
            n_cell[i].folded = fold_case(pbyte[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < PAT_REGS; r++) begin
                r_pat[r] <= '0;
            end
            for (int i = 0; i < PATTERN_MAX; i++) begin
                r_cell[i] <= '0;
            end
            r_len <= '0;
        end else if (i_wr) begin
            r_pat  <= n_pat;
            r_len  <= n_len;
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

/* rtl/core/glob_wildcard_matcher.sv */
`timescale 1ns / 1ps
// glob wildcard matcher top level: cell chain, item handshake, result register
// a result is registered and shown in the cycle after its end-of-name item is accepted
// throughput: one item per cycle while the result register is free or being drained
// the star closure ripples combinationally through 32 cells like a carry chain
// reset (synchronous, active low): empty pattern, start state, no result pending
// a configuration write restarts the automaton; no clearing pass is needed
module glob_wildcard_matcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gwm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [gwm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] name_char
    input  logic                           i_s_axis_tlast,  // end_of_name
    // result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata   // [0] matched, [7:1] zero
);
    import gwm_pkg::*;

    t_cell_cfg             cell_cfg [PATTERN_MAX];
    logic [CHAR_W-1:0]     char_folded;
    logic [PATTERN_MAX:0]  carry;
    logic [POS_W-1:0]      closed;
    logic [PATTERN_MAX-1:0] step_self;
    logic [PATTERN_MAX-1:0] step_next;
    logic [POS_W-1:0]      r_seed;
    logic [POS_W-1:0]      n_seed;
    logic                  r_out_valid;
    logic                  r_out_match;
    logic                  in_acc;
    logic                  is_end;
    logic                  cfg_wr;
    logic                  result;
    logic [POS_W:0]        use_ext;   // in-use bits with a set bit below and a clear bit above

    // config is always taken; the user must send it only while the block is idle, the block does not enforce this
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    gwm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cell  (cell_cfg)
    );

    // a new item goes in whenever the result register is free or being drained
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    // a zero name byte ends the name just like tlast
    assign is_end          = i_s_axis_tlast | (i_s_axis_tdata == CHAR_NUL);
    assign char_folded     = fold_case(i_s_axis_tdata);

    // cell chain: r_seed holds the raw position set, cells apply star closure
    assign carry[0] = 1'b0;
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        gwm_cell u_cell (
            .i_cfg       (cell_cfg[g]),
            .i_char      (char_folded),
            .i_seed      (r_seed[g]),
            .i_carry     (carry[g]),
            .o_closed    (closed[g]),
            .o_carry     (carry[g+1]),
            .o_step_self (step_self[g]),
            .o_step_next (step_next[g])
        );
    end
    // position after the last pattern byte has no byte of its own
    assign closed[PATTERN_MAX] = r_seed[PATTERN_MAX] | carry[PATTERN_MAX];

    // match when the position right after the last in-use byte is active
    always_comb begin
        use_ext = '0;
        use_ext[0] = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            use_ext[i+1] = cell_cfg[i].in_use;
        end
        result = 1'b0;
        for (int i = 0; i < POS_W; i++) begin
            result = result | (closed[i] & use_ext[i] & ~use_ext[i+1]);
        end
    end

    // next raw position set after one name character
    always_comb begin
        n_seed    = '0;
        n_seed[0] = step_self[0];
        for (int i = 1; i < PATTERN_MAX; i++) begin
            n_seed[i] = step_self[i] | step_next[i-1];
        end
        n_seed[PATTERN_MAX] = step_next[PATTERN_MAX-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= POS_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr || (in_acc && is_end)) begin
                // back to the start position; closure is applied by the cells
                r_seed <= POS_W'(1);
            end else if (in_acc) begin
                r_seed <= n_seed;
            end
            if (in_acc && is_end) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with its valid
    always_ff @(posedge i_clk) begin
        if (in_acc && is_end) begin
            r_out_match <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_match};

endmodule

/* rtl/core/gwm_checker.sv */
`timescale 1ns / 1ps
// port-level checks of the glob wildcard matcher and their binding
module gwm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);
    logic in_acc;
    logic in_end;

    assign in_acc = i_s_axis_tvalid & o_s_axis_tready;
    assign in_end = i_s_axis_tlast | (i_s_axis_tdata == 8'h00);

    // every end-of-name item produces a result in the next cycle
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_end) |=> o_m_axis_tvalid)
        else $error("end of name gave no result");

    // a character item never creates a result by itself
    a_char_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !in_end && (!o_m_axis_tvalid || i_m_axis_tready)) |=> !o_m_axis_tvalid)
        else $error("result without end of name");

    // input side never stalls while the result register is empty
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with no result pending");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

    // only the match flag may be set
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:1] == 7'd0))
        else $error("result padding not zero");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
